@@ hw/rtl/dfr_pkg.sv @@
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared constants, codes and word types of the diagnostic frame receiver.
// ----------------------------------------------------------------------------
package dfr_pkg;

    localparam int FRAME_BYTES   = 10;
    localparam int TYPE_SLOTS    = 7;
    localparam int REQUEST_COUNT = 4;

    localparam int NUM_BUFS  = TYPE_SLOTS + 1;
    localparam int BUF_W     = $clog2(NUM_BUFS);
    localparam int POS_W     = $clog2(FRAME_BYTES);
    localparam int MEM_DEPTH = NUM_BUFS * FRAME_BYTES;
    localparam int MEM_W     = $clog2(MEM_DEPTH);
    localparam int REQ_W     = (REQUEST_COUNT > 1) ? $clog2(REQUEST_COUNT) : 1;

    localparam logic [7:0] HEADER_MARK = 8'h55;
    localparam logic [7:0] IDLE_BYTE   = 8'hFF;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_ACCEPT = 2'd1,
        ST_REJECT = 2'd2,
        ST_SILENT = 2'd3
    } t_status;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
        logic [2:0] read_slot;
        logic [3:0] read_offset;
    } t_dfr_in;

    typedef struct packed {
        logic [1:0]  frame_status;
        logic [7:0]  frame_kind;
        logic [1:0]  next_request;
        logic [31:0] good_count;
        logic [31:0] bad_count;
        logic [31:0] silent_count;
        logic [7:0]  read_data;
        logic        read_valid;
    } t_dfr_out;

    typedef struct packed {
        logic             ld;
        logic             rd;
        logic [2:0]       rd_slot;
        logic [3:0]       rd_off;
        logic             wr;
        logic [POS_W-1:0] wr_pos;
        logic [7:0]       wr_byte;
        logic             commit;
        logic [7:0]       commit_kind;
    } t_store_ctl;

endpackage

@@ hw/rtl/dfr_store.sv @@
// ----------------------------------------------------------------------------
// dfr_store
// Frame buffer memory with one spare buffer: bytes land in the spare buffer,
// and an accepted frame swaps the spare with its type's buffer.
// ----------------------------------------------------------------------------
module dfr_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dfr_pkg::t_store_ctl i_ctl,
    output logic [7:0]          o_rd_data,
    output logic                o_rd_valid
);
    import dfr_pkg::*;

    logic [7:0]            r_mem [MEM_DEPTH];
    logic [BUF_W-1:0]      r_map [TYPE_SLOTS];
    logic [BUF_W-1:0]      n_map [TYPE_SLOTS];
    logic [BUF_W-1:0]      r_stage, n_stage;
    logic [TYPE_SLOTS-1:0] r_valid, n_valid;
    logic [7:0]            r_rd_data;
    logic                  r_rd_valid;
    logic [BUF_W-1:0]      rd_buf;
    logic [BUF_W-1:0]      cm_buf;
    logic                  rd_hit;
    logic [MEM_W-1:0]      rd_addr;
    logic [MEM_W-1:0]      wr_addr;

    always_comb begin
        rd_buf  = '0;
        rd_hit  = 1'b0;
        cm_buf  = '0;
        n_map   = r_map;
        n_stage = r_stage;
        n_valid = r_valid;
        for (int s = 0; s < TYPE_SLOTS; s++) begin
            if (int'(i_ctl.rd_slot) == s) begin
                rd_buf = r_map[s];
                rd_hit = r_valid[s];
            end
            if (int'(i_ctl.commit_kind) == s) begin
                cm_buf = r_map[s];
            end
        end
        if (int'(i_ctl.rd_off) >= FRAME_BYTES) begin
            rd_hit = 1'b0;
        end
        if (i_ctl.commit) begin
            n_stage = cm_buf;
            for (int s = 0; s < TYPE_SLOTS; s++) begin
                if (int'(i_ctl.commit_kind) == s) begin
                    n_map[s]   = r_stage;
                    n_valid[s] = 1'b1;
                end
            end
        end
    end

    assign rd_addr = MEM_W'(rd_buf) * MEM_W'(FRAME_BYTES) + MEM_W'(i_ctl.rd_off);
    assign wr_addr = MEM_W'(r_stage) * MEM_W'(FRAME_BYTES) + MEM_W'(i_ctl.wr_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage    <= BUF_W'(TYPE_SLOTS);
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            for (int s = 0; s < TYPE_SLOTS; s++) begin
                r_map[s] <= BUF_W'(s);
            end
        end else begin
            r_stage <= n_stage;
            r_valid <= n_valid;
            r_map   <= n_map;
            if (i_ctl.ld) begin
                r_rd_valid <= i_ctl.rd & rd_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[wr_addr] <= i_ctl.wr_byte;
        end
        if (i_ctl.ld && i_ctl.rd) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_rd_data  = r_rd_valid ? r_rd_data : 8'h00;
    assign o_rd_valid = r_rd_valid;

endmodule

@@ hw/rtl/diag_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// diag_frame_receiver
// Gathers received response bytes into frames, classifies each complete
// frame, keeps per-type frame copies and totals, and serves byte reads.
// ----------------------------------------------------------------------------
// One word is taken per clock while the input is not stalled; its result
// passes through an input register, one pass of compare and byte-sum logic,
// and the result register with the frame buffer's registered read port beside it.
// A stalled result holds the word behind it in the input register; otherwise
// the input never stalls. Frames are kept in a memory of one buffer more than
// there are types; an accepted frame is never copied, its buffer is swapped in
// for its type. Slot valid bits are cleared by reset, so the block is ready at
// once.
module diag_frame_receiver (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  dfr_pkg::t_dfr_in  i_in_data,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output dfr_pkg::t_dfr_out o_out_data,
    input  logic              i_out_stall
);
    import dfr_pkg::*;

    t_dfr_in          r_in;
    logic             r_in_vld;
    logic             r_out_vld;
    t_status          r_status, n_status;
    logic [7:0]       r_kind_out;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_sum, n_sum;
    logic             r_ones, n_ones;
    logic [7:0]       r_hdr;
    logic [7:0]       r_type;
    logic [REQ_W-1:0] r_req, n_req;
    logic [31:0]      r_good, n_good;
    logic [31:0]      r_bad, n_bad;
    logic [31:0]      r_silent, n_silent;

    logic       advance;
    logic       take;
    logic       is_byte;
    logic       byte_go;
    logic       last;
    logic [7:0] sum_next;
    logic       ones_next;
    logic       frame_ok;
    t_store_ctl store_ctl;
    logic [7:0] rd_data;
    logic       rd_valid;

    assign advance    = r_in_vld & (~r_out_vld | ~i_out_stall);
    assign o_in_stall = r_in_vld & ~advance;
    assign take       = i_in_valid & ~o_in_stall;

    assign is_byte   = (r_in.req_type == REQ_BYTE);
    assign byte_go   = advance & is_byte;
    assign last      = (r_pos == POS_W'(FRAME_BYTES - 1));
    assign sum_next  = r_sum + r_in.data_byte;
    assign ones_next = r_ones & (r_in.data_byte == IDLE_BYTE);
    assign frame_ok  = (r_hdr == HEADER_MARK) && (int'(r_type) < TYPE_SLOTS)
                       && (sum_next == 8'h00);

    always_comb begin
        n_status = ST_NONE;
        n_pos    = r_pos;
        n_sum    = r_sum;
        n_ones   = r_ones;
        n_req    = r_req;
        n_good   = r_good;
        n_bad    = r_bad;
        n_silent = r_silent;
        if (is_byte && last) begin
            if (ones_next) begin
                n_status = ST_SILENT;
            end else if (frame_ok) begin
                n_status = ST_ACCEPT;
            end else begin
                n_status = ST_REJECT;
            end
        end
        if (byte_go) begin
            if (last) begin
                n_pos  = '0;
                n_sum  = 8'h00;
                n_ones = 1'b1;
                case (n_status)
                    ST_SILENT: n_silent = r_silent + 32'd1;
                    ST_ACCEPT: n_good   = r_good + 32'd1;
                    ST_REJECT: n_bad    = r_bad + 32'd1;
                    default:   n_silent = r_silent;
                endcase
                if (n_status != ST_SILENT) begin
                    n_req = (r_req == REQ_W'(REQUEST_COUNT - 1)) ? '0 : r_req + 1'b1;
                end
            end else begin
                n_pos  = r_pos + 1'b1;
                n_sum  = sum_next;
                n_ones = ones_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_pos     <= '0;
            r_sum     <= 8'h00;
            r_ones    <= 1'b1;
            r_req     <= '0;
            r_good    <= '0;
            r_bad     <= '0;
            r_silent  <= '0;
        end else begin
            if (take) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            r_pos    <= n_pos;
            r_sum    <= n_sum;
            r_ones   <= n_ones;
            r_req    <= n_req;
            r_good   <= n_good;
            r_bad    <= n_bad;
            r_silent <= n_silent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in <= i_in_data;
        end
        if (byte_go && r_pos == POS_W'(0)) begin
            r_hdr <= r_in.data_byte;
        end
        if (byte_go && r_pos == POS_W'(1)) begin
            r_type <= r_in.data_byte;
        end
        if (advance) begin
            r_status   <= n_status;
            r_kind_out <= (is_byte && last) ? r_type : 8'h00;
        end
    end

    always_comb begin
        store_ctl.ld          = advance;
        store_ctl.rd          = ~is_byte;
        store_ctl.rd_slot     = r_in.read_slot;
        store_ctl.rd_off      = r_in.read_offset;
        store_ctl.wr          = byte_go;
        store_ctl.wr_pos      = r_pos;
        store_ctl.wr_byte     = r_in.data_byte;
        store_ctl.commit      = byte_go & last & (n_status == ST_ACCEPT);
        store_ctl.commit_kind = r_type;
    end

    dfr_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (store_ctl),
        .o_rd_data  (rd_data),
        .o_rd_valid (rd_valid)
    );

    assign o_out_valid             = r_out_vld;
    assign o_out_data.frame_status = r_status;
    assign o_out_data.frame_kind   = r_kind_out;
    assign o_out_data.next_request = 2'(r_req);
    assign o_out_data.good_count   = r_good;
    assign o_out_data.bad_count    = r_bad;
    assign o_out_data.silent_count = r_silent;
    assign o_out_data.read_data    = rd_data;
    assign o_out_data.read_valid   = rd_valid;

endmodule

@@ hw/rtl/dfr_check.sv @@
// ----------------------------------------------------------------------------
// dfr_check
// Port-level checks of the diagnostic frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module dfr_check (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input dfr_pkg::t_dfr_out o_out_data,
    input logic              i_out_stall
);
    import dfr_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("result word changed while stalled");

    // reset leaves totals cleared and no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_out_data.good_count == 32'd0
            && o_out_data.bad_count == 32'd0 && o_out_data.silent_count == 32'd0))
        else $error("state not cleared by reset");

    // a read word carries no frame result
    a_read_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.read_valid) |->
            (o_out_data.frame_status == ST_NONE && o_out_data.frame_kind == 8'h00))
        else $error("read word carries frame result");

    // input side only stalls behind a pending result
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty result register");

endmodule

bind diag_frame_receiver dfr_check u_check (.*);

@@ tb/sv/diag_frame_receiver_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diag_frame_receiver_tb
// Self-checking bench for the diagnostic frame receiver. Byte and read words
// go in from a queue. They are silent frames, good frames, frames broken in
// header, type or checksum, and noise, with reads of every slot and offset
// mixed in. Each taken word runs through a behavioral copy of the receiver
// to predict its result. Results are checked in order, field by field, under
// random sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module diag_frame_receiver_tb;
    import dfr_pkg::*;

    typedef enum logic [1:0] {
        PH_STEADY      = 2'd0,
        PH_SEND_GAPS   = 2'd1,
        PH_RECV_STALLS = 2'd2,
        PH_BOTH        = 2'd3
    } t_idle_phase;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_dfr_in  i_in_data   = '0;
    logic     i_out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_dfr_out o_out_data;

    t_dfr_in     pending_words[$];
    t_dfr_out    due_results[$];
    t_dfr_out    result_want;
    int          words_total    = 0;
    int          words_sent     = 0;
    int          words_accepted = 0;
    int          fail_count     = 0;
    logic        in_taken       = 1'b0;
    logic        hold_off       = 1'b0;
    t_idle_phase idle_phase;
    int          send_idle_pct;
    int          stall_pct;

    logic [7:0]  asm_bytes [FRAME_BYTES];
    int          asm_pos;
    logic [7:0]  asm_sum;
    logic        asm_all_ff;
    logic [7:0]  slot_bytes [TYPE_SLOTS][FRAME_BYTES];
    logic        slot_full [TYPE_SLOTS];
    int          req_idx;
    logic [31:0] n_good;
    logic [31:0] n_bad;
    logic [31:0] n_silent;

    diag_frame_receiver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    assign idle_phase    = t_idle_phase'((words_sent / 70) % 4);
    assign send_idle_pct = (idle_phase == PH_SEND_GAPS) ? 54 :
                           (idle_phase == PH_BOTH) ? 12 : 0;
    assign stall_pct     = (idle_phase == PH_RECV_STALLS) ? 54 :
                           (idle_phase == PH_BOTH) ? 12 : 0;

    task automatic clear_receiver_state();
        asm_pos    = 0;
        asm_sum    = 8'd0;
        asm_all_ff = 1'b1;
        req_idx    = 0;
        n_good     = '0;
        n_bad      = '0;
        n_silent   = '0;
        for (int s = 0; s < TYPE_SLOTS; s++) begin
            slot_full[s] = 1'b0;
            for (int k = 0; k < FRAME_BYTES; k++) begin
                slot_bytes[s][k] = 8'd0;
            end
        end
        for (int k = 0; k < FRAME_BYTES; k++) begin
            asm_bytes[k] = 8'd0;
        end
    endtask

    function automatic t_dfr_out classify_word(input t_dfr_in w);
        t_dfr_out   r;
        logic [7:0] kind_b;
        r = '0;
        if (w.req_type == REQ_READ) begin
            if (w.read_slot < TYPE_SLOTS && w.read_offset < FRAME_BYTES &&
                slot_full[w.read_slot]) begin
                r.read_data  = slot_bytes[w.read_slot][w.read_offset];
                r.read_valid = 1'b1;
            end
        end else begin
            asm_bytes[asm_pos] = w.data_byte;
            asm_sum = asm_sum + w.data_byte;
            if (w.data_byte != IDLE_BYTE) begin
                asm_all_ff = 1'b0;
            end
            asm_pos++;
            if (asm_pos == FRAME_BYTES) begin
                kind_b       = asm_bytes[1];
                r.frame_kind = kind_b;
                if (asm_all_ff) begin
                    n_silent++;
                    r.frame_status = ST_SILENT;
                end else begin
                    if (asm_bytes[0] == HEADER_MARK && kind_b < TYPE_SLOTS &&
                        asm_sum == 8'd0) begin
                        for (int k = 0; k < FRAME_BYTES; k++) begin
                            slot_bytes[kind_b][k] = asm_bytes[k];
                        end
                        slot_full[kind_b] = 1'b1;
                        n_good++;
                        r.frame_status = ST_ACCEPT;
                    end else begin
                        n_bad++;
                        r.frame_status = ST_REJECT;
                    end
                    req_idx = (req_idx + 1) % REQUEST_COUNT;
                end
                asm_pos    = 0;
                asm_sum    = 8'd0;
                asm_all_ff = 1'b1;
            end
        end
        r.next_request = 2'(req_idx);
        r.good_count   = n_good;
        r.bad_count    = n_bad;
        r.silent_count = n_silent;
        return r;
    endfunction

    task automatic queue_byte(input logic [7:0] b);
        t_dfr_in w;
        w.req_type    = REQ_BYTE;
        w.data_byte   = b;
        w.read_slot   = 3'($urandom);
        w.read_offset = 4'($urandom);
        pending_words.push_back(w);
    endtask

    task automatic queue_read(input logic [2:0] slot, input logic [3:0] off);
        t_dfr_in w;
        w.req_type    = REQ_READ;
        w.data_byte   = 8'($urandom);
        w.read_slot   = slot;
        w.read_offset = off;
        pending_words.push_back(w);
    endtask

    task automatic queue_random_read();
        logic [3:0] off;
        off = ($urandom_range(99) < 80) ? 4'($urandom_range(FRAME_BYTES - 1))
                                        : 4'($urandom_range(15));
        queue_read(3'($urandom_range(7)), off);
    endtask

    task automatic queue_frame(input logic [FRAME_BYTES-1:0][7:0] fb,
                               input int read_pct);
        for (int k = 0; k < FRAME_BYTES; k++) begin
            queue_byte(fb[k]);
            if ($urandom_range(99) < read_pct) begin
                queue_random_read();
            end
        end
    endtask

    task automatic queue_random_frame();
        logic [FRAME_BYTES-1:0][7:0] fb;
        logic [7:0]                  s;
        int                          pick;
        pick  = $urandom_range(99);
        fb[0] = HEADER_MARK;
        fb[1] = 8'($urandom_range(TYPE_SLOTS - 1));
        for (int k = 2; k < FRAME_BYTES; k++) begin
            fb[k] = 8'($urandom);
        end
        if (pick >= 62 && pick < 70) begin
            fb[0] = 8'($urandom);
            if (fb[0] == HEADER_MARK) begin
                fb[0] = 8'h54;
            end
        end else if (pick >= 70 && pick < 78) begin
            fb[1] = 8'($urandom_range(255, TYPE_SLOTS));
        end
        s = 8'd0;
        for (int k = 0; k < FRAME_BYTES - 1; k++) begin
            s = s + fb[k];
        end
        fb[FRAME_BYTES-1] = 8'd0 - s;
        if (pick >= 78 && pick < 86) begin
            fb[FRAME_BYTES-1] = fb[FRAME_BYTES-1] + 8'($urandom_range(255, 1));
        end else if (pick >= 86 && pick < 96) begin
            for (int k = 0; k < FRAME_BYTES; k++) begin
                fb[k] = IDLE_BYTE;
            end
            if (pick >= 92) begin
                fb[$urandom_range(FRAME_BYTES - 1)] = 8'($urandom_range(254));
            end
        end else if (pick >= 96) begin
            for (int k = 0; k < FRAME_BYTES; k++) begin
                fb[k] = 8'($urandom);
            end
        end
        queue_frame(fb, 12);
    endtask

    task automatic compare_field(input string fname, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %h actual %h", $time, fname, want, got);
            fail_count++;
        end
    endtask

    // word driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (pending_words.size() > 0 &&
                (hold_off || $urandom_range(99) >= send_idle_pct)) begin
                i_in_data  <= pending_words.pop_front();
                i_in_valid <= 1'b1;
                words_sent <= words_sent + 1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= hold_off || ($urandom_range(99) < stall_pct);
        end
    end

    // long receiver hold-off so the block backs up
    initial begin
        while (words_sent < 160) @(negedge i_clk);
        hold_off <= 1'b1;
        repeat (120) @(negedge i_clk);
        hold_off <= 1'b0;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                due_results.push_back(classify_word(i_in_data));
                words_accepted <= words_accepted + 1;
            end
            if (o_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    $display("%0t ns: unexpected result word %h", $time, o_out_data);
                    fail_count++;
                end else begin
                    result_want = due_results.pop_front();
                    compare_field("frame_status", 32'(result_want.frame_status),
                                  32'(o_out_data.frame_status));
                    compare_field("frame_kind", 32'(result_want.frame_kind),
                                  32'(o_out_data.frame_kind));
                    compare_field("next_request", 32'(result_want.next_request),
                                  32'(o_out_data.next_request));
                    compare_field("good_count", result_want.good_count,
                                  o_out_data.good_count);
                    compare_field("bad_count", result_want.bad_count,
                                  o_out_data.bad_count);
                    compare_field("silent_count", result_want.silent_count,
                                  o_out_data.silent_count);
                    compare_field("read_data", 32'(result_want.read_data),
                                  32'(o_out_data.read_data));
                    compare_field("read_valid", 32'(result_want.read_valid),
                                  32'(o_out_data.read_valid));
                end
            end
        end
    end

    initial begin
        logic [FRAME_BYTES-1:0][7:0] fb;
        clear_receiver_state();

        // reads of empty slots, an out-of-range slot and an out-of-range offset
        queue_read(3'd0, 4'd0);
        queue_read(3'd7, 4'd3);
        queue_read(3'd6, 4'd15);
        // silent frame
        for (int k = 0; k < FRAME_BYTES; k++) begin
            fb[k] = IDLE_BYTE;
        end
        queue_frame(fb, 0);
        // good frame of the highest type with extreme bytes
        fb[0] = HEADER_MARK;
        fb[1] = 8'(TYPE_SLOTS - 1);
        fb[2] = 8'h00;
        fb[3] = 8'hFF;
        fb[4] = 8'h80;
        fb[5] = 8'h01;
        fb[6] = 8'h7F;
        fb[7] = 8'hFE;
        fb[8] = 8'h00;
        fb[9] = 8'hA8;
        queue_frame(fb, 0);
        queue_read(3'(TYPE_SLOTS - 1), 4'd0);
        queue_read(3'(TYPE_SLOTS - 1), 4'(FRAME_BYTES - 1));
        queue_read(3'(TYPE_SLOTS - 1), 4'(FRAME_BYTES));

        while (pending_words.size() < 475) begin
            queue_random_frame();
        end
        words_total = pending_words.size();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (words_accepted < words_total) @(negedge i_clk);
        while (due_results.size() > 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (due_results.size() > 0) begin
            $display("%0t ns: %0d results never arrived", $time, due_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
